[src/dslrs_pkg.sv]
// ---------------------------------------------------------------------------
// dslrs_pkg: shared types and constants for leaving-row selection
// Word layouts between front, queue and back end.
// ---------------------------------------------------------------------------
package dslrs_pkg;

  localparam int VIOL_W  = 31;
  localparam int CAP_W   = 17;
  localparam int SCORE_W = 33;
  localparam logic [CAP_W-1:0] CAP_MIN = 17'd5;

  localparam logic [0:0] REG_WEIGHT_IN_VIOL = 1'b0;
  localparam logic [0:0] REG_VIOL_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [VIOL_W-1:0] violation;
    logic [VIOL_W-1:0] dual_weight;
    logic [23:0]       basic_variable;
    logic              bbar_negative;
    logic              first_item;
    logic              last_item;
    logic [CAP_W-1:0]  cap;
  } dslrs_item_t;

  typedef struct packed {
    logic        found;
    logic [23:0] leaving_variable;
    logic        leave_at_lower;
  } dslrs_res_t;

endpackage

[src/dual_simplex_leaving_row_select_top.sv]
// ---------------------------------------------------------------------------
// dual_simplex_leaving_row_select_top: leaving-row selection for dual simplex
// Scores each row, keeps the best, emits the choice on the last row.
// ---------------------------------------------------------------------------
// The back end takes a new word only once done with the last; its pace is set
//   by the bit-serial restoring divider (one quotient bit/cycle), and a scan's
//   last word also waits until the result queue has room.
// Input queue of 4 words lets the front keep accepting while the back divides.
// Reset (rst_n low, synchronous) empties queues, sets best to -1.0, cap to 5,
//   weight_in_violation to 1 and the threshold to 0.
module dual_simplex_leaving_row_select_top #(
  parameter int FRACTION_BITS = 16,
  parameter int VARIABLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [30:0]              in_violation,
  input  logic [30:0]              in_dual_weight,
  input  logic [VARIABLE_BITS-1:0] in_basic_variable,
  input  logic                     in_bbar_negative,
  input  logic                     in_first_item,
  input  logic                     in_last_item,
  input  logic [15:0]              in_cap_fraction,
  input  logic [15:0]              in_scan_length,
  output logic                     empty,
  input  logic                     pop,
  output logic                     out_found,
  output logic [VARIABLE_BITS-1:0] out_leaving_variable,
  output logic                     out_leave_at_lower,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [30:0]              cfg_data
);
  import dslrs_pkg::*;

  logic          wiv_r;
  logic [30:0]   thr_r;
  logic          f_push, q_full, q_empty, q_pop, r_push, r_full;
  dslrs_item_t   f_item, q_item;
  dslrs_res_t    r_data, r_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiv_r <= 1'b1;
      thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_IN_VIOL: wiv_r <= cfg_data[0];
        REG_VIOL_THRESHOLD: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dslrs_front u_front (
    .clk, .rst_n, .push, .full,
    .violation(in_violation), .dual_weight(in_dual_weight),
    .basic_variable(24'(in_basic_variable)), .bbar_negative(in_bbar_negative),
    .first_item(in_first_item), .last_item(in_last_item),
    .cap_fraction(in_cap_fraction), .scan_length(in_scan_length),
    .q_push(f_push), .q_full, .q_item(f_item)
  );

  // decouple front and back
  dslrs_fifo #(.W($bits(dslrs_item_t)), .DEPTH(4)) u_iq (
    .clk, .rst_n, .push(f_push), .wdata(f_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_item)
  );

  dslrs_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .weight_in_violation(wiv_r), .violation_threshold(thr_r),
    .q_empty, .q_item, .q_pop, .r_push, .r_full, .r_data
  );

  // result queue holds finished words until popped
  dslrs_fifo #(.W($bits(dslrs_res_t)), .DEPTH(2)) u_rq (
    .clk, .rst_n, .push(r_push), .wdata(r_data), .full(r_full),
    .pop, .empty, .rdata(r_out)
  );

  assign out_found            = r_out.found;
  assign out_leaving_variable = r_out.leaving_variable[VARIABLE_BITS-1:0];
  assign out_leave_at_lower   = r_out.leave_at_lower;
endmodule

[src/dslrs_front.sv]
// ---------------------------------------------------------------------------
// dslrs_front: input stage
// Register one word per cycle when not full, with its improvement cap.
// ---------------------------------------------------------------------------
module dslrs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [30:0]         violation,
  input  logic [30:0]         dual_weight,
  input  logic [23:0]         basic_variable,
  input  logic                bbar_negative,
  input  logic                first_item,
  input  logic                last_item,
  input  logic [15:0]         cap_fraction,
  input  logic [15:0]         scan_length,
  output logic                q_push,
  input  logic                q_full,
  output dslrs_pkg::dslrs_item_t q_item
);
  import dslrs_pkg::*;

  logic [31:0]      prod;
  logic [CAP_W-1:0] cap_raw;
  logic             vld_r;
  dslrs_item_t      item_r;

  assign prod    = cap_fraction * scan_length;
  assign cap_raw = CAP_W'(({1'b0, prod} + 33'h0FFFF) >> 16);
  assign full    = vld_r && q_full;
  assign q_push  = vld_r;
  assign q_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!full) begin
      vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      item_r.violation      <= violation;
      item_r.dual_weight    <= dual_weight;
      item_r.basic_variable <= basic_variable;
      item_r.bbar_negative  <= bbar_negative;
      item_r.first_item     <= first_item;
      item_r.last_item      <= last_item;
      item_r.cap            <= (cap_raw < CAP_MIN) ? CAP_MIN : cap_raw;
    end
  end
endmodule

[src/dslrs_fifo.sv]
// ---------------------------------------------------------------------------
// dslrs_fifo: small word queue
// Decouple front and back end; registered storage, pointer based.
// ---------------------------------------------------------------------------
module dslrs_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

[src/dslrs_back.sv]
// ---------------------------------------------------------------------------
// dslrs_back: scoring and selection engine; divides unless weight_in_violation
// Restoring division one quotient bit per cycle, then compare and update.
// ---------------------------------------------------------------------------
module dslrs_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  weight_in_violation,
  input  logic [30:0]           violation_threshold,
  input  logic                  q_empty,
  input  dslrs_pkg::dslrs_item_t q_item,
  output logic                  q_pop,
  output logic                  r_push,
  input  logic                  r_full,
  output dslrs_pkg::dslrs_res_t r_data
);
  import dslrs_pkg::*;

  localparam int NUM_W = VIOL_W + FRACTION_BITS;
  localparam int CW    = $clog2(NUM_W + 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_UPD = 2'd2, S_OUT = 2'd3;

  logic [1:0]         st_r;
  logic [CW-1:0]      cnt_r;
  logic [NUM_W-1:0]   num_r;
  logic [VIOL_W:0]    rem_r;
  logic [VIOL_W:0]    rem_sh;
  logic [VIOL_W-1:0]  score_r;
  dslrs_item_t        it_r;
  logic [SCORE_W-1:0] best_r;
  logic [23:0]        bvar_r;
  logic               blow_r, have_r, stop_r;
  logic [CAP_W-1:0]   cnt_imp_r, cap_r;
  logic [SCORE_W-1:0] sum;
  logic               better;

  assign rem_sh = {rem_r[VIOL_W-1:0], num_r[NUM_W-1]};
  assign sum    = best_r + SCORE_W'(violation_threshold);
  assign better = $signed({2'b00, score_r}) > $signed(sum);
  assign q_pop  = (st_r == S_IDLE) && !q_empty;
  assign r_push = (st_r == S_OUT);
  assign r_data = '{found: have_r, leaving_variable: have_r ? bvar_r : '0,
                    leave_at_lower: have_r & blow_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      best_r    <= -SCORE_W'(1 << FRACTION_BITS);
      bvar_r    <= '0;
      blow_r    <= 1'b0;
      have_r    <= 1'b0;
      stop_r    <= 1'b0;
      cnt_imp_r <= '0;
      cap_r     <= CAP_MIN;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            it_r <= q_item;
            if (q_item.first_item) begin
              best_r    <= -SCORE_W'(1 << FRACTION_BITS);
              bvar_r    <= '0;
              blow_r    <= 1'b0;
              have_r    <= 1'b0;
              stop_r    <= 1'b0;
              cnt_imp_r <= '0;
              cap_r     <= q_item.cap;
            end
            num_r   <= {q_item.violation, FRACTION_BITS'(0)};
            rem_r   <= '0;
            cnt_r   <= '0;
            score_r <= q_item.violation;
            st_r    <= weight_in_violation ? S_UPD : S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          num_r <= {num_r[NUM_W-2:0], (rem_sh >= {1'b0, it_r.dual_weight})};
          rem_r <= (rem_sh >= {1'b0, it_r.dual_weight}) ?
                   rem_sh - {1'b0, it_r.dual_weight} : rem_sh;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(NUM_W - 1)) st_r <= S_UPD;
        end
        S_UPD: begin
          if (!weight_in_violation) begin
            if (it_r.dual_weight == '0 || |num_r[NUM_W-1:VIOL_W])
              score_r <= '1;
            else
              score_r <= num_r[VIOL_W-1:0];
          end
          if (!stop_r && cnt_r != CW'(NUM_W + 1)) begin
            cnt_r <= CW'(NUM_W + 1);
          end else begin
            if (!stop_r && better) begin
              best_r <= {2'b00, score_r};
              bvar_r <= it_r.basic_variable;
              blow_r <= it_r.bbar_negative;
              have_r <= 1'b1;
              if (cnt_imp_r > cap_r) stop_r <= 1'b1;
              else cnt_imp_r <= cnt_imp_r + 1'b1;
            end
            st_r <= it_r.last_item ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (!r_full) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[src/dslrs_checker.sv]
// ---------------------------------------------------------------------------
// dslrs_checker: port-level checks for leaving-row selection
// Watch the result side for consistency over time.
// ---------------------------------------------------------------------------
module dslrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic        out_found,
  input logic [15:0] out_leaving_variable,
  input logic        out_leave_at_lower
);
  a_nf_var: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_found) |-> (out_leaving_variable == '0 && !out_leave_at_lower))
    else $error("empty result carries data");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_found)))
    else $error("waiting result changed");
  a_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result after reset");
endmodule

bind dual_simplex_leaving_row_select_top dslrs_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_found,
  .out_leaving_variable(16'(out_leaving_variable)), .out_leave_at_lower
);
